// ===== rtl/point_cloud_grid_binner_top_defines.svh =====
// Assertion macros shared by the point cloud grid binner RTL.
// Depends on nothing; each macro expects signals named clk and rst in scope.
`ifndef POINT_CLOUD_GRID_BINNER_TOP_DEFINES_SVH
`define POINT_CLOUD_GRID_BINNER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pcgb_pkg.sv =====
// Shared types, codes and helpers for the point cloud grid binner.
// Depends on nothing; used by every RTL module of the block but pcgb_div.
`timescale 1ns / 1ps
`default_nettype none
package pcgb_pkg;

  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_COUNT_BITS = 16;

  // Widest cell address over the legal parameter range (4096 x 4096).
  localparam int ADDR_W_MAX = 24;
  // Width of a limited grid size (up to 4096).
  localparam int LIM_W = 13;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_RECIP     = 3'd2;
  localparam logic [2:0] REG_COLS      = 3'd3;
  localparam logic [2:0] REG_ROWS      = 3'd4;
  localparam logic [2:0] REG_MODE      = 3'd5;
  localparam logic [2:0] REG_FILTER_ON = 3'd6;
  localparam logic [2:0] REG_MASK      = 3'd7;

  // Input actions. The unused code three behaves as a read.
  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_READ     = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;
  localparam logic [1:0] ACT_READ_ALT = 2'd3;

  // Aggregation modes.
  localparam logic [2:0] MODE_LAST = 3'd1;
  localparam logic [2:0] MODE_MIN  = 3'd2;
  localparam logic [2:0] MODE_MAX  = 3'd3;
  localparam logic [2:0] MODE_MEAN = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_OUTSIDE = 3'd1;
  localparam logic [2:0] ST_REJECT  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  // Operations handed from the front to the back.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_OUT    = 3'd3;
  localparam logic [2:0] OP_REJECT = 3'd4;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] cell_recip;
    logic [8:0]  grid_cols;
    logic [8:0]  grid_rows;
    logic [2:0]  aggregation_mode;
    logic        class_filter_on;
    logic [63:0] class_mask;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            op;
    logic [7:0]            ocol;
    logic [7:0]            orow;
    logic [ADDR_W_MAX-1:0] addr;
    logic [31:0]           z;
  } entry_t;

  // Saturate a signed value to the 32 bit signed range.
  function automatic logic [31:0] sat32(input logic signed [48:0] v);
    logic signed [48:0] hi;
    logic signed [48:0] lo;
    begin
      hi = 49'sh0_7FFF_FFFF;
      lo = -49'sh0_8000_0000;
      if (v > hi) sat32 = 32'h7FFF_FFFF;
      else if (v < lo) sat32 = 32'h8000_0000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pcgb_queue.sv =====
// Two-entry queue between the classifying front and the executing back.
// Depends on pcgb_pkg for the entry type and on the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "point_cloud_grid_binner_top_defines.svh"
module pcgb_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pcgb_pkg::entry_t wr_entry,
  output logic                 full,
  input  wire logic            pop,
  output pcgb_pkg::entry_t     rd_entry,
  output logic                 empty
);
  import pcgb_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `PCGB_ASSERT_NOW(a_no_push_full, push, !full || pop, "queue pushed while full")
  `PCGB_ASSERT_NOW(a_no_pop_empty, pop, !empty, "queue popped while empty")
  `PCGB_ASSERT_NOW(a_count_range, 1'b1, count != 2'd3, "queue count out of range")

endmodule
`default_nettype wire

// ===== rtl/pcgb_front.sv =====
// Front end: takes commands, maps point positions to cells and classifies them.
// Depends on pcgb_pkg; feeds pcgb_queue.
`timescale 1ns / 1ps
`default_nettype none
module pcgb_front #(
  parameter int MAX_COLS = pcgb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = pcgb_pkg::DEF_MAX_ROWS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pcgb_pkg::cfg_t  cfg,
  input  wire logic            start,
  input  wire logic [1:0]      action,
  input  wire logic [31:0]     x_coord,
  input  wire logic [31:0]     y_coord,
  input  wire logic [31:0]     elevation,
  input  wire logic [7:0]      class_id,
  input  wire logic [7:0]      read_col,
  input  wire logic [7:0]      read_row,
  output logic                 busy,
  output logic                 push,
  output pcgb_pkg::entry_t     entry,
  input  wire logic            full
);
  import pcgb_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_CLS  = 2'd2;

  logic [1:0]  fstate;
  logic [1:0]  act;
  logic [32:0] mag_x, mag_y;
  logic        neg_x, neg_y;
  logic [63:0] prod_x, prod_y;
  logic [31:0] z;
  logic [7:0]  cls;
  logic [7:0]  rcol, rrow;

  logic [32:0] dx, dy;
  logic [64:0] full_x, full_y;
  logic [64:0] rnd_x, rnd_y;
  logic [32:0] cx, cy;
  logic        in_x, in_y;
  logic [LIM_W-1:0] ncols, nrows;
  logic        reject;
  logic [LIM_W-1:0] col_i, row_i;

  assign busy = (fstate != F_IDLE);

  assign dx = {x_coord[31], x_coord} - {cfg.origin_x[31], cfg.origin_x};
  assign dy = {y_coord[31], y_coord} - {cfg.origin_y[31], cfg.origin_y};

  assign full_x = 65'(mag_x) * 65'(cfg.cell_recip);
  assign full_y = 65'(mag_y) * 65'(cfg.cell_recip);

  assign ncols = (LIM_W'(cfg.grid_cols) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                           : LIM_W'(cfg.grid_cols);
  assign nrows = (LIM_W'(cfg.grid_rows) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                           : LIM_W'(cfg.grid_rows);

  // Round half up for a positive offset; a negative one only lands in cell 0
  // when it rounds there.
  always_comb begin
    rnd_x = {1'b0, prod_x} + 65'h0_8000_0000;
    rnd_y = {1'b0, prod_y} + 65'h0_8000_0000;
    cx    = neg_x ? 33'd0 : rnd_x[64:32];
    cy    = neg_y ? 33'd0 : rnd_y[64:32];
    in_x  = (cx < 33'(ncols)) && (!neg_x || (prod_x <= 64'h8000_0000));
    in_y  = (cy < 33'(nrows)) && (!neg_y || (prod_y <= 64'h8000_0000));
    col_i = cx[LIM_W-1:0];
    row_i = cy[LIM_W-1:0];
    reject = cfg.class_filter_on && ((cls > 8'd63) || !cfg.class_mask[cls[5:0]]);
  end

  always_comb begin
    entry.z    = z;
    entry.ocol = 8'd0;
    entry.orow = 8'd0;
    entry.addr = '0;
    entry.op   = OP_OUT;
    if (act == ACT_CLEAR) begin
      entry.op = OP_CLEAR;
    end else if (act[0]) begin
      entry.ocol = rcol;
      entry.orow = rrow;
      entry.addr = ADDR_W_MAX'(32'(rrow) * 32'(MAX_COLS) + 32'(rcol));
      if ((LIM_W'(rcol) < ncols) && (LIM_W'(rrow) < nrows)) entry.op = OP_READ;
    end else if (in_x && in_y) begin
      entry.ocol = col_i[7:0];
      entry.orow = row_i[7:0];
      entry.addr = ADDR_W_MAX'(32'(row_i) * 32'(MAX_COLS) + 32'(col_i));
      entry.op   = reject ? OP_REJECT : OP_ADD;
    end
  end

  assign push = (fstate == F_CLS) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      unique case (fstate)
        F_IDLE: if (start) fstate <= F_MUL;
        F_MUL:  fstate <= F_CLS;
        F_CLS:  if (!full) fstate <= F_IDLE;
        default: fstate <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fstate == F_IDLE && start) begin
      act   <= action;
      neg_x <= dx[32];
      neg_y <= dy[32];
      mag_x <= dx[32] ? (~dx + 33'd1) : dx;
      mag_y <= dy[32] ? (~dy + 33'd1) : dy;
      z     <= elevation;
      cls   <= class_id;
      rcol  <= read_col;
      rrow  <= read_row;
    end
    if (fstate == F_MUL) begin
      prod_x <= full_x[63:0];
      prod_y <= full_y[63:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcgb_div.sv =====
// Bit-serial restoring divider: 48 bit magnitude by an unsigned count.
// Depends on nothing but its parameter; used by pcgb_back for mean reads.
`timescale 1ns / 1ps
`default_nettype none
module pcgb_div #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [47:0]           dividend,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output logic                       done,
  output logic [47:0]                quotient
);
  logic                  running;
  logic [5:0]            cnt;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [COUNT_BITS:0]   shifted;
  logic                  ge;

  assign shifted = {rem, quotient[47]};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == 6'd0);
      if (start) running <= 1'b1;
      else if (running && cnt == 6'd0) running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= 6'd47;
    end else if (running) begin
      rem      <= ge ? COUNT_BITS'(shifted - {1'b0, dvs}) : shifted[COUNT_BITS-1:0];
      quotient <= {quotient[46:0], ge};
      cnt      <= cnt - 6'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcgb_back.sv =====
// Back end: cell memories, aggregation, reads with mean division, clear walk.
// Depends on pcgb_pkg, pcgb_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "point_cloud_grid_binner_top_defines.svh"
module pcgb_back #(
  parameter int MAX_COLS   = pcgb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = pcgb_pkg::DEF_MAX_ROWS,
  parameter int COUNT_BITS = pcgb_pkg::DEF_COUNT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pcgb_pkg::cfg_t   cfg,
  input  wire pcgb_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  done,
  output logic [2:0]            status,
  output logic [7:0]            cell_col,
  output logic [7:0]            cell_row,
  output logic [31:0]           cell_result,
  output logic [15:0]           hit_count
);
  import pcgb_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_MEM  = 3'd2;
  localparam logic [2:0] B_EXEC = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;

  logic [COUNT_BITS-1:0] hits_mem [DEPTH];
  logic [47:0]           val_mem  [DEPTH];

  logic [2:0]            bstate;
  entry_t                ent;
  logic [AW-1:0]         ptr;
  logic                  clr_emit;
  logic [COUNT_BITS-1:0] hits_rd;
  logic [47:0]           val_rd;
  logic                  mean_neg;

  logic                  h_we, v_we;
  logic [AW-1:0]         h_wa;
  logic [COUNT_BITS-1:0] h_wd;
  logic [47:0]           v_wd;
  logic [AW-1:0]         raddr;

  logic [47:0]           z48;
  logic [48:0]           sum49;
  logic [47:0]           sum48;
  logic [COUNT_BITS-1:0] n_inc;
  logic                  is_full;
  logic                  div_start, div_done;
  logic [47:0]           div_q;
  logic [47:0]           val_mag;
  logic [48:0]           q_signed;

  assign raddr   = ent.addr[AW-1:0];
  assign z48     = {{16{ent.z[31]}}, ent.z};
  assign sum49   = {val_rd[47], val_rd} + {z48[47], z48};
  assign n_inc   = hits_rd + COUNT_BITS'(1);
  assign is_full = (hits_rd == '1);
  assign val_mag = val_rd[47] ? (~val_rd + 48'd1) : val_rd;
  assign q_signed = mean_neg ? (~{1'b0, div_q} + 49'd1) : {1'b0, div_q};

  // Sums saturate to the 48 bit signed range.
  always_comb begin
    if (sum49[48] != sum49[47]) sum48 = sum49[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    else sum48 = sum49[47:0];
  end

  always_comb begin
    v_wd = val_rd;
    if (hits_rd == '0) begin
      v_wd = z48;
    end else begin
      unique case (cfg.aggregation_mode)
        MODE_LAST: v_wd = z48;
        MODE_MIN:  if ($signed(val_rd) > $signed(z48)) v_wd = z48;
        MODE_MAX:  if ($signed(val_rd) < $signed(z48)) v_wd = z48;
        MODE_MEAN: v_wd = sum48;
        default:   v_wd = val_rd;
      endcase
    end
  end

  always_comb begin
    h_we = 1'b0;
    v_we = 1'b0;
    h_wa = raddr;
    h_wd = n_inc;
    if (bstate == B_CLR) begin
      h_we = 1'b1;
      h_wa = ptr;
      h_wd = '0;
    end else if (bstate == B_EXEC && ent.op == OP_ADD && !is_full) begin
      h_we = 1'b1;
      v_we = 1'b1;
    end
  end

  assign pop       = (bstate == B_IDLE) && !empty;
  assign div_start = (bstate == B_EXEC) && (ent.op == OP_READ) &&
                     (cfg.aggregation_mode == MODE_MEAN) && (hits_rd != '0);

  pcgb_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (val_mag),
    .divisor  (hits_rd),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    hits_rd <= hits_mem[raddr];
    val_rd  <= val_mem[raddr];
    if (h_we) hits_mem[h_wa] <= h_wd;
    if (v_we) val_mem[raddr] <= v_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate   <= B_CLR;
      ptr      <= '0;
      clr_emit <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (bstate)
        B_CLR: begin
          ptr <= ptr + AW'(1);
          if (ptr == AW'(DEPTH - 1)) begin
            bstate <= B_IDLE;
            if (clr_emit) begin
              done        <= 1'b1;
              status      <= ST_CLEARED;
              cell_col    <= 8'd0;
              cell_row    <= 8'd0;
              cell_result <= 32'd0;
              hit_count   <= 16'd0;
            end
          end
        end
        B_IDLE: begin
          if (!empty) begin
            ent    <= head;
            bstate <= B_MEM;
          end
        end
        B_MEM: bstate <= B_EXEC;
        B_EXEC: begin
          bstate      <= B_IDLE;
          cell_col    <= ent.ocol;
          cell_row    <= ent.orow;
          cell_result <= 32'd0;
          hit_count   <= 16'd0;
          unique case (ent.op)
            OP_CLEAR: begin
              bstate   <= B_CLR;
              ptr      <= '0;
              clr_emit <= 1'b1;
            end
            OP_OUT: begin
              done   <= 1'b1;
              status <= ST_OUTSIDE;
            end
            OP_REJECT: begin
              done   <= 1'b1;
              status <= ST_REJECT;
            end
            OP_ADD: begin
              done      <= 1'b1;
              status    <= is_full ? ST_FULL : ST_ADDED;
              hit_count <= is_full ? 16'(hits_rd) : 16'(n_inc);
            end
            OP_READ: begin
              hit_count <= 16'(hits_rd);
              status    <= ST_READ;
              mean_neg  <= val_rd[47];
              if (div_start) begin
                bstate <= B_DIV;
              end else begin
                done        <= 1'b1;
                cell_result <= (hits_rd == '0) ? 32'd0 : sat32({val_rd[47], val_rd});
              end
            end
            default: bstate <= B_IDLE;
          endcase
        end
        B_DIV: begin
          if (div_done) begin
            done        <= 1'b1;
            cell_result <= sat32(q_signed);
            bstate      <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

  `PCGB_ASSERT_NOW(a_div_in_state, div_done, bstate == B_DIV, "divider finished outside divide")
  `PCGB_ASSERT_NEXT(a_mem_to_exec, bstate == B_MEM, bstate == B_EXEC, "memory read not followed")
  `PCGB_ASSERT_NEXT(a_single_beat, done, !done, "two result beats in a row")

endmodule
`default_nettype wire

// ===== rtl/point_cloud_grid_binner_top.sv =====
// Top level of the point cloud grid binner: configuration registers,
// front end, queue and back end. Depends on pcgb_pkg and all pcgb_* modules.
//
//   channel   | handshake            | payload
//   ----------+----------------------+--------------------------------------------
//   command   | start / busy         | action, x_coord, y_coord, elevation,
//             |                      | class_id, read_col, read_row
//   result    | done (one cycle)     | status, cell_col, cell_row, cell_result,
//             |                      | hit_count
//   config    | cfg_we               | cfg_idx, cfg_data
//
// A command beat is taken when start is high and busy is low. The front end
// handles each command in three steps (latch and offset, Q0.32 multiply, cell
// mapping) and takes no new command until the last one is in the queue. The
// back end handles each command in three steps (queue pop, registered memory
// read, execute); a mean read then waits on the bit-serial divider, and a clear
// walks the count memory one cell per cycle. After reset the same walk zeroes
// every count; commands are taken and queued meanwhile. Each result beat is
// shown for exactly one cycle on done; the receiver cannot hold it off, and
// results leave in command order.
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_grid_binner_top #(
  parameter int MAX_COLS   = pcgb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = pcgb_pkg::DEF_MAX_ROWS,
  parameter int COUNT_BITS = pcgb_pkg::DEF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_coord,
  input  wire logic [31:0] elevation,
  input  wire logic [7:0]  class_id,
  input  wire logic [7:0]  read_col,
  input  wire logic [7:0]  read_row,
  output logic             done,
  output logic [2:0]       status,
  output logic [7:0]       cell_col,
  output logic [7:0]       cell_row,
  output logic [31:0]      cell_result,
  output logic [15:0]      hit_count
);
  import pcgb_pkg::*;

  cfg_t   cfg;
  entry_t q_wr, q_rd;
  logic   q_push, q_pop, q_full, q_empty;

  // Configuration registers take their write in the cycle of the enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x         <= 32'd0;
      cfg.origin_y         <= 32'd0;
      cfg.cell_recip       <= 32'hFFFF_FFFF;
      cfg.grid_cols        <= 9'd256;
      cfg.grid_rows        <= 9'd256;
      cfg.aggregation_mode <= MODE_LAST;
      cfg.class_filter_on  <= 1'b0;
      cfg.class_mask       <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ORIGIN_X:  cfg.origin_x         <= cfg_data[31:0];
        REG_ORIGIN_Y:  cfg.origin_y         <= cfg_data[31:0];
        REG_RECIP:     cfg.cell_recip       <= cfg_data[31:0];
        REG_COLS:      cfg.grid_cols        <= cfg_data[8:0];
        REG_ROWS:      cfg.grid_rows        <= cfg_data[8:0];
        REG_MODE:      cfg.aggregation_mode <= cfg_data[2:0];
        REG_FILTER_ON: cfg.class_filter_on  <= cfg_data[0];
        REG_MASK:      cfg.class_mask       <= cfg_data;
        default:       cfg.class_mask       <= cfg.class_mask;
      endcase
    end
  end

  // The front end maps each point to a cell and decides its fate.
  pcgb_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .action    (action),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .elevation (elevation),
    .class_id  (class_id),
    .read_col  (read_col),
    .read_row  (read_row),
    .busy      (busy),
    .push      (q_push),
    .entry     (q_wr),
    .full      (q_full)
  );

  // The queue lets the front keep going while the back divides or clears.
  pcgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .empty    (q_empty)
  );

  // The back end owns the cell memories and produces every result beat.
  pcgb_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (q_rd),
    .empty       (q_empty),
    .pop         (q_pop),
    .done        (done),
    .status      (status),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .cell_result (cell_result),
    .hit_count   (hit_count)
  );

endmodule
`default_nettype wire
